>>> src/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// ecpa_pkg
// Shared types, codes and widths of the elliptic-curve point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpa_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int SCALAR_BITS = 16;
  localparam int FIDX_W      = $clog2(FIELD_BITS);
  localparam int SIDX_W      = $clog2(SCALAR_BITS);
  localparam int CFG_IDX_W   = 1;
  localparam int NUM_REGS    = 16;

  // operation codes of the input word
  localparam logic [1:0] OPC_ADD  = 2'd0;
  localparam logic [1:0] OPC_SUB  = 2'd1;
  localparam logic [1:0] OPC_MUL  = 2'd2;
  localparam logic [1:0] OPC_NONE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;

  typedef struct packed {
    logic [1:0]             operation;
    logic [FIELD_BITS-1:0]  px;
    logic [FIELD_BITS-1:0]  py;
    logic [FIELD_BITS-1:0]  qx;
    logic [FIELD_BITS-1:0]  qy;
    logic [SCALAR_BITS-1:0] scalar;
  } ecpa_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] rx;
    logic [FIELD_BITS-1:0] ry;
    logic                  at_infinity;
  } ecpa_out_t;

  // datapath register file addresses
  typedef enum logic [3:0] {
    RA_ZERO, RA_ONE, RA_A, RA_PX, RA_PY, RA_QX, RA_QY, RA_RX, RA_RY,
    RA_T0, RA_T1, RA_T2, RA_T3, RA_T4, RA_T5
  } reg_addr_e;

  typedef enum logic [3:0] {
    DP_ZERO, DP_ONE, DP_RED, DP_MOV, DP_ADD, DP_SUB, DP_MUL, DP_CMP, DP_OUT
  } dp_op_e;

  // source of a reduction
  typedef enum logic [2:0] {
    RS_A, RS_PX, RS_PY, RS_QX, RS_QY
  } red_sel_e;

  typedef struct packed {
    logic              valid;
    logic              load;
    dp_op_e            op;
    reg_addr_e         dst;
    reg_addr_e         src_a;
    reg_addr_e         src_b;
    red_sel_e          red_sel;
    logic [FIDX_W-1:0] e_idx;
    logic [SIDX_W-1:0] k_idx;
    logic              inf;
  } ecpa_cmd_t;

  typedef struct packed {
    logic       done;
    logic       eq;
    logic       az;
    logic       ebit;
    logic       kbit;
    logic       m_small;
    logic [1:0] op;
    logic       out_full;
  } ecpa_stat_t;

endpackage

`default_nettype wire

>>> src/ecpa_dp.sv
// ----------------------------------------------------------------------------
// ecpa_dp
// Field datapath: register file, modular add/sub, bit-serial modular
// multiply and reduction, compare flags, configuration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpa_dp import ecpa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [FIELD_BITS-1:0] cfg_data_i,
  input  wire ecpa_in_t              in_data_i,
  input  wire ecpa_cmd_t             cmd_i,
  output ecpa_stat_t                 stat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ecpa_out_t                  out_data_o
);

  typedef enum logic [1:0] {DS_IDLE, DS_EXEC, DS_ITER} dp_state_e;

  dp_state_e             ds_q;
  ecpa_cmd_t             cmd_q;
  logic [FIELD_BITS-1:0] opa_q, opb_q, shf_q, acc_q;
  logic [FIDX_W-1:0]     cnt_q;
  logic [FIELD_BITS-1:0] rf_q [NUM_REGS];
  ecpa_in_t              in_q;
  logic [FIELD_BITS-1:0] curve_a_q, modulus_q;
  logic                  eq_q, az_q, done_q;
  ecpa_out_t             out_q;
  logic                  out_valid_q;

  logic [FIELD_BITS:0]   add_s, sub_s, dbl_s, dbl_r, mac_s, mac_r;
  logic [FIELD_BITS-1:0] add_res, sub_res, acc_nx, red_src, exp_e;
  logic [FIELD_BITS-1:0] wr_data;
  logic                  wr_en;
  logic [FIELD_BITS:0]   m_ext;

  assign m_ext = {1'b0, modulus_q};

  // modular add and subtract, operands below the modulus
  assign add_s   = {1'b0, opa_q} + {1'b0, opb_q};
  assign add_res = (add_s >= m_ext) ? FIELD_BITS'(add_s - m_ext) : add_s[FIELD_BITS-1:0];
  assign sub_s   = (opa_q >= opb_q) ? ({1'b0, opa_q} - {1'b0, opb_q})
                                    : ({1'b0, opa_q} + m_ext - {1'b0, opb_q});
  assign sub_res = sub_s[FIELD_BITS-1:0];

  // one step of shift-and-add multiply or of restoring reduction
  assign dbl_s  = {acc_q, (cmd_q.op == DP_RED) ? shf_q[FIELD_BITS-1] : 1'b0};
  assign dbl_r  = (dbl_s >= m_ext) ? (dbl_s - m_ext) : dbl_s;
  assign mac_s  = dbl_r + {1'b0, opa_q};
  assign mac_r  = (mac_s >= m_ext) ? (mac_s - m_ext) : mac_s;
  assign acc_nx = ((cmd_q.op == DP_MUL) && shf_q[FIELD_BITS-1]) ? mac_r[FIELD_BITS-1:0]
                                                               : dbl_r[FIELD_BITS-1:0];

  always_comb begin
    case (cmd_i.red_sel)
      RS_PX:   red_src = in_q.px;
      RS_PY:   red_src = in_q.py;
      RS_QX:   red_src = in_q.qx;
      RS_QY:   red_src = in_q.qy;
      default: red_src = curve_a_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = opa_q;
    if (ds_q == DS_ITER) begin
      wr_en   = (cnt_q == '0);
      wr_data = acc_nx;
    end else if (ds_q == DS_EXEC) begin
      case (cmd_q.op)
        DP_ZERO: begin wr_en = 1'b1; wr_data = '0; end
        DP_ONE:  begin wr_en = 1'b1; wr_data = FIELD_BITS'(1); end
        DP_MOV:  begin wr_en = 1'b1; wr_data = opa_q; end
        DP_ADD:  begin wr_en = 1'b1; wr_data = add_res; end
        DP_SUB:  begin wr_en = 1'b1; wr_data = sub_res; end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // exponent of the inverse, p - 2
  assign exp_e = modulus_q - FIELD_BITS'(2);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_q[cmd_q.dst] <= wr_data;
    end
    if ((ds_q == DS_IDLE) && cmd_i.valid) begin
      opa_q <= rf_q[cmd_i.src_a];
      opb_q <= rf_q[cmd_i.src_b];
      shf_q <= (cmd_i.op == DP_RED) ? red_src : rf_q[cmd_i.src_b];
      acc_q <= '0;
      cnt_q <= FIDX_W'(FIELD_BITS - 1);
    end else if (ds_q == DS_ITER) begin
      acc_q <= acc_nx;
      shf_q <= {shf_q[FIELD_BITS-2:0], 1'b0};
      cnt_q <= cnt_q - FIDX_W'(1);
    end
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_q        <= DS_IDLE;
      cmd_q       <= '0;
      eq_q        <= 1'b0;
      az_q        <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      curve_a_q   <= FIELD_BITS'(1);
      modulus_q   <= FIELD_BITS'(11);
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CURVE_A) begin
          curve_a_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_MODULUS) begin
          modulus_q <= cfg_data_i;
        end
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ds_q)
        DS_IDLE: begin
          if (cmd_i.valid) begin
            cmd_q <= cmd_i;
            ds_q  <= ((cmd_i.op == DP_MUL) || (cmd_i.op == DP_RED)) ? DS_ITER : DS_EXEC;
          end
        end
        DS_EXEC: begin
          if (cmd_q.op == DP_CMP) begin
            eq_q <= (opa_q == opb_q);
            az_q <= (opa_q == '0);
          end
          if (cmd_q.op == DP_OUT) begin
            out_valid_q <= 1'b1;
            if (cmd_q.inf) begin
              out_q <= '{rx: '0, ry: '0, at_infinity: 1'b1};
            end else begin
              out_q <= '{rx: opa_q, ry: opb_q, at_infinity: 1'b0};
            end
          end
          done_q <= 1'b1;
          ds_q   <= DS_IDLE;
        end
        DS_ITER: begin
          if (cnt_q == '0) begin
            done_q <= 1'b1;
            ds_q   <= DS_IDLE;
          end
        end
        default: ds_q <= DS_IDLE;
      endcase
    end
  end

  assign stat_o = '{
    done:     done_q,
    eq:       eq_q,
    az:       az_q,
    ebit:     exp_e[cmd_i.e_idx],
    kbit:     in_q.scalar[cmd_i.k_idx],
    m_small:  (modulus_q < FIELD_BITS'(2)),
    op:       in_q.operation,
    out_full: out_valid_q
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cmd_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid |-> (ds_q == DS_IDLE))
    else $error("command issued while datapath busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held for more than one cycle");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && (cmd_i.op == DP_OUT)) |-> !out_valid_q)
    else $error("output word overwritten");

  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.at_infinity) |-> ((out_q.rx == '0) && (out_q.ry == '0)))
    else $error("infinity with nonzero coordinates");

endmodule

`default_nettype wire

>>> src/ecpa_ctrl.sv
// ----------------------------------------------------------------------------
// ecpa_ctrl
// Sequencer for point add, doubling, inversion and double-and-add; issues
// one datapath command at a time and branches on the returned flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpa_ctrl import ecpa_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire ecpa_stat_t stat_i,
  output ecpa_cmd_t       cmd_o
);

  typedef enum logic [1:0] {CS_IDLE, CS_ISSUE, CS_WAIT} ctl_state_e;
  typedef enum logic [1:0] {M_ADD, M_DBL, M_INC} mode_e;
  typedef enum logic [5:0] {
    S_START, S_ZERO, S_ONE, S_RA, S_RPX, S_RPY, S_RQX, S_RQY, S_CP, S_CQ, S_NEG,
    S_SETUP, S_ENTRY, S_COPYX, S_COPYY, S_CX, S_CY, S_SQ, S_X2, S_X3, S_XA, S_Y2,
    S_DN, S_DD, S_ZCHK, S_IZERO, S_ISET, S_ISQ, S_IMUL, S_LAM, S_L2, S_L3, S_L4,
    S_L5, S_L6, S_L7, S_L8, S_L9, S_RET, S_OUT
  } step_e;

  ctl_state_e        state_q, state_d;
  step_e             pc_q, pc_d;
  mode_e             mode_q, mode_d;
  logic              pinf_q, pinf_d, qinf_q, qinf_d, rinf_q, rinf_d;
  logic [FIDX_W-1:0] eidx_q, eidx_d;
  logic [SIDX_W-1:0] kidx_q, kidx_d;

  reg_addr_e sx, sy, tx, ty, cx, cy;
  logic      sinf, tinf, branch_only, go;
  ecpa_cmd_t cmd;

  always_comb begin
    unique case (mode_q)
      M_DBL: begin
        sx = RA_RX; sy = RA_RY; tx = RA_RX; ty = RA_RY; sinf = rinf_q; tinf = rinf_q;
      end
      M_INC: begin
        sx = RA_RX; sy = RA_RY; tx = RA_PX; ty = RA_PY; sinf = rinf_q; tinf = pinf_q;
      end
      default: begin
        sx = RA_PX; sy = RA_PY; tx = RA_QX; ty = RA_QY; sinf = pinf_q; tinf = qinf_q;
      end
    endcase
    cx = sinf ? tx : sx;
    cy = sinf ? ty : sy;
  end

  // command of the current step
  always_comb begin
    cmd         = '0;
    cmd.op      = DP_MOV;
    cmd.dst     = RA_T0;
    cmd.src_a   = RA_ZERO;
    cmd.src_b   = RA_ZERO;
    cmd.red_sel = RS_A;
    cmd.e_idx   = eidx_q;
    cmd.k_idx   = kidx_q;
    cmd.inf     = rinf_q;
    branch_only = 1'b0;
    unique case (pc_q)
      S_START, S_SETUP, S_ENTRY, S_RET: branch_only = 1'b1;
      S_ZERO:  begin cmd.op = DP_ZERO; cmd.dst = RA_ZERO; end
      S_ONE:   begin cmd.op = DP_ONE;  cmd.dst = RA_ONE;  end
      S_RA:    begin cmd.op = DP_RED; cmd.dst = RA_A;  cmd.red_sel = RS_A;  end
      S_RPX:   begin cmd.op = DP_RED; cmd.dst = RA_PX; cmd.red_sel = RS_PX; end
      S_RPY:   begin cmd.op = DP_RED; cmd.dst = RA_PY; cmd.red_sel = RS_PY; end
      S_RQX:   begin cmd.op = DP_RED; cmd.dst = RA_QX; cmd.red_sel = RS_QX; end
      S_RQY:   begin cmd.op = DP_RED; cmd.dst = RA_QY; cmd.red_sel = RS_QY; end
      S_CP:    begin cmd.op = DP_CMP; cmd.src_a = RA_PX; cmd.src_b = RA_PY; end
      S_CQ:    begin cmd.op = DP_CMP; cmd.src_a = RA_QX; cmd.src_b = RA_QY; end
      S_NEG:   begin
        cmd.op = DP_SUB; cmd.dst = RA_QY; cmd.src_a = RA_ZERO; cmd.src_b = RA_QY;
      end
      S_COPYX: begin cmd.op = DP_MOV; cmd.dst = RA_RX; cmd.src_a = cx; end
      S_COPYY: begin cmd.op = DP_MOV; cmd.dst = RA_RY; cmd.src_a = cy; end
      S_CX:    begin cmd.op = DP_CMP; cmd.src_a = sx; cmd.src_b = tx; end
      S_CY:    begin cmd.op = DP_CMP; cmd.src_a = sy; cmd.src_b = ty; end
      S_SQ:    begin cmd.op = DP_MUL; cmd.dst = RA_T0; cmd.src_a = sx; cmd.src_b = sx; end
      S_X2:    begin cmd.op = DP_ADD; cmd.dst = RA_T1; cmd.src_a = RA_T0; cmd.src_b = RA_T0; end
      S_X3:    begin cmd.op = DP_ADD; cmd.dst = RA_T0; cmd.src_a = RA_T1; cmd.src_b = RA_T0; end
      S_XA:    begin cmd.op = DP_ADD; cmd.dst = RA_T0; cmd.src_a = RA_T0; cmd.src_b = RA_A; end
      S_Y2:    begin cmd.op = DP_ADD; cmd.dst = RA_T1; cmd.src_a = sy; cmd.src_b = sy; end
      S_DN:    begin cmd.op = DP_SUB; cmd.dst = RA_T0; cmd.src_a = ty; cmd.src_b = sy; end
      S_DD:    begin cmd.op = DP_SUB; cmd.dst = RA_T1; cmd.src_a = tx; cmd.src_b = sx; end
      S_ZCHK:  begin cmd.op = DP_CMP; cmd.src_a = RA_T1; cmd.src_b = RA_T1; end
      S_IZERO: begin cmd.op = DP_MOV; cmd.dst = RA_T2; cmd.src_a = RA_ZERO; end
      S_ISET:  begin cmd.op = DP_MOV; cmd.dst = RA_T2; cmd.src_a = RA_ONE; end
      S_ISQ:   begin cmd.op = DP_MUL; cmd.dst = RA_T2; cmd.src_a = RA_T2; cmd.src_b = RA_T2; end
      S_IMUL:  begin cmd.op = DP_MUL; cmd.dst = RA_T2; cmd.src_a = RA_T2; cmd.src_b = RA_T1; end
      S_LAM:   begin cmd.op = DP_MUL; cmd.dst = RA_T4; cmd.src_a = RA_T0; cmd.src_b = RA_T2; end
      S_L2:    begin cmd.op = DP_MUL; cmd.dst = RA_T5; cmd.src_a = RA_T4; cmd.src_b = RA_T4; end
      S_L3:    begin cmd.op = DP_SUB; cmd.dst = RA_T5; cmd.src_a = RA_T5; cmd.src_b = sx; end
      S_L4:    begin cmd.op = DP_SUB; cmd.dst = RA_T5; cmd.src_a = RA_T5; cmd.src_b = tx; end
      S_L5:    begin cmd.op = DP_SUB; cmd.dst = RA_T0; cmd.src_a = sx; cmd.src_b = RA_T5; end
      S_L6:    begin cmd.op = DP_MUL; cmd.dst = RA_T0; cmd.src_a = RA_T4; cmd.src_b = RA_T0; end
      S_L7:    begin cmd.op = DP_SUB; cmd.dst = RA_T0; cmd.src_a = RA_T0; cmd.src_b = sy; end
      S_L8:    begin cmd.op = DP_MOV; cmd.dst = RA_RX; cmd.src_a = RA_T5; end
      S_L9:    begin cmd.op = DP_MOV; cmd.dst = RA_RY; cmd.src_a = RA_T0; end
      S_OUT:   begin cmd.op = DP_OUT; cmd.src_a = RA_RX; cmd.src_b = RA_RY; end
      default: branch_only = 1'b1;
    endcase
    cmd.valid = (state_q == CS_ISSUE) && !branch_only &&
                !((pc_q == S_OUT) && stat_i.out_full);
    cmd.load  = (state_q == CS_IDLE) && in_valid_i;
  end

  assign go = ((state_q == CS_ISSUE) && branch_only) || ((state_q == CS_WAIT) && stat_i.done);

  // step sequencing
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    mode_d  = mode_q;
    pinf_d  = pinf_q;
    qinf_d  = qinf_q;
    rinf_d  = rinf_q;
    eidx_d  = eidx_q;
    kidx_d  = kidx_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_ISSUE;
          pc_d    = S_START;
        end
      end
      CS_ISSUE: if (cmd.valid) state_d = CS_WAIT;
      CS_WAIT:  if (stat_i.done) state_d = (pc_q == S_OUT) ? CS_IDLE : CS_ISSUE;
      default:  state_d = CS_IDLE;
    endcase
    if (go) begin
      case (pc_q)
        S_START: begin
          if (stat_i.m_small || (stat_i.op == OPC_NONE)) begin
            rinf_d = 1'b1;
            pc_d   = S_OUT;
          end else begin
            pc_d = S_ZERO;
          end
        end
        S_ZERO: pc_d = S_ONE;
        S_ONE:  pc_d = S_RA;
        S_RA:   pc_d = S_RPX;
        S_RPX:  pc_d = S_RPY;
        S_RPY:  pc_d = S_RQX;
        S_RQX:  pc_d = S_RQY;
        S_RQY:  pc_d = S_CP;
        S_CP: begin
          pinf_d = stat_i.eq && stat_i.az;
          pc_d   = S_CQ;
        end
        S_CQ: begin
          qinf_d = stat_i.eq && stat_i.az;
          pc_d   = ((stat_i.op == OPC_SUB) && !(stat_i.eq && stat_i.az)) ? S_NEG : S_SETUP;
        end
        S_NEG: pc_d = S_SETUP;
        S_SETUP: begin
          if (stat_i.op == OPC_MUL) begin
            rinf_d = 1'b1;
            kidx_d = SIDX_W'(SCALAR_BITS - 1);
            mode_d = M_DBL;
          end else begin
            mode_d = M_ADD;
          end
          pc_d = S_ENTRY;
        end
        S_ENTRY: pc_d = (sinf || tinf) ? S_COPYX : S_CX;
        S_COPYX: pc_d = S_COPYY;
        S_COPYY: begin
          rinf_d = sinf ? tinf : 1'b0;
          pc_d   = S_RET;
        end
        S_CX: pc_d = stat_i.eq ? S_CY : S_DN;
        S_CY: begin
          if (!stat_i.eq || stat_i.az) begin
            rinf_d = 1'b1;
            pc_d   = S_RET;
          end else begin
            pc_d = S_SQ;
          end
        end
        S_SQ:  pc_d = S_X2;
        S_X2:  pc_d = S_X3;
        S_X3:  pc_d = S_XA;
        S_XA:  pc_d = S_Y2;
        S_Y2:  pc_d = S_ZCHK;
        S_DN:  pc_d = S_DD;
        S_DD:  pc_d = S_ZCHK;
        S_ZCHK: pc_d = stat_i.az ? S_IZERO : S_ISET;
        S_IZERO: pc_d = S_LAM;
        S_ISET: begin
          eidx_d = FIDX_W'(FIELD_BITS - 1);
          pc_d   = S_ISQ;
        end
        S_ISQ, S_IMUL: begin
          if ((pc_q == S_ISQ) && stat_i.ebit) begin
            pc_d = S_IMUL;
          end else if (eidx_q == '0) begin
            pc_d = S_LAM;
          end else begin
            eidx_d = eidx_q - FIDX_W'(1);
            pc_d   = S_ISQ;
          end
        end
        S_LAM: pc_d = S_L2;
        S_L2:  pc_d = S_L3;
        S_L3:  pc_d = S_L4;
        S_L4:  pc_d = S_L5;
        S_L5:  pc_d = S_L6;
        S_L6:  pc_d = S_L7;
        S_L7:  pc_d = S_L8;
        S_L8:  pc_d = S_L9;
        S_L9: begin
          rinf_d = 1'b0;
          pc_d   = S_RET;
        end
        S_RET: begin
          if (mode_q == M_DBL && stat_i.kbit) begin
            mode_d = M_INC;
            pc_d   = S_ENTRY;
          end else if (mode_q == M_ADD || kidx_q == '0) begin
            pc_d = S_OUT;
          end else begin
            kidx_d = kidx_q - SIDX_W'(1);
            mode_d = M_DBL;
            pc_d   = S_ENTRY;
          end
        end
        default: pc_d = S_START;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      pc_q    <= S_START;
      mode_q  <= M_ADD;
      pinf_q  <= 1'b0;
      qinf_q  <= 1'b0;
      rinf_q  <= 1'b1;
      eidx_q  <= '0;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      mode_q  <= mode_d;
      pinf_q  <= pinf_d;
      qinf_q  <= qinf_d;
      rinf_q  <= rinf_d;
      eidx_q  <= eidx_d;
      kidx_q  <= kidx_d;
    end
  end

  assign in_stall_o = (state_q != CS_IDLE);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

>>> src/ec_point_add_scalar_multiply.sv
// ----------------------------------------------------------------------------
// ec_point_add_scalar_multiply
// Affine point add, subtract and scalar multiply on y^2 = x^3 + a x + b mod p.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one word with the operation,
// P, Q and the scalar. in_stall_o is low only while the block is idle, so
// one word is worked on at a time. Output channel: out_valid_o / out_stall_i
// carry rx, ry and at_infinity from an output register; a new word is taken
// while the last result still waits there, and the next result is held
// back until that register has been emptied.
// The work is done by datapath commands: a modular multiply or a reduction
// runs one bit a cycle. The inverse is a left-to-right power ladder of up to
// 32 multiplies, and a scalar multiply takes up to 32 point operations.
// Modulus below two or operation code 3 gives infinity.
// Reset sets curve_a to 1 and modulus to 11 and leaves the block idle with
// no result pending; the user must write configuration only while idle, and
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_point_add_scalar_multiply import ecpa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [FIELD_BITS-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire ecpa_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ecpa_out_t                  out_data_o
);

  ecpa_cmd_t  cmd;
  ecpa_stat_t stat;

  ecpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ecpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sim/ec_point_add_scalar_multiply_test.sv
// ----------------------------------------------------------------------------
// ec_point_add_scalar_multiply_test
// Drives point add, subtract and scalar multiply words through the point unit
// under several curve settings, predicts every result in the testbench and
// checks each result word field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_point_add_scalar_multiply_test;
  import ecpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic             x_inf;
    logic [63:0]      x;
    logic [63:0]      y;
  } point_t;

  typedef struct {
    ecpa_in_t  word;
    logic      has_known;
    ecpa_out_t known;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [FIELD_BITS-1:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  ecpa_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  ecpa_out_t out_data_o;

  ec_point_add_scalar_multiply DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [63:0] coef_a = 64'd1;
  logic [63:0] prime_p = 64'd11;
  ecpa_out_t   pending_results[$];
  int          err_count = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          hold_done = 1'b0;

  function automatic logic [63:0] mod_mul(logic [63:0] u, logic [63:0] v);
    return (u * v) % prime_p;
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] u, logic [63:0] v);
    return (u + prime_p - v) % prime_p;
  endfunction

  // inverse by Fermat power, zero maps to zero
  function automatic logic [63:0] mod_inv(logic [63:0] d);
    logic [63:0] e, r, b;
    e = prime_p - 64'd2;
    r = 64'd1 % prime_p;
    b = d % prime_p;
    if (b == 0) return 64'd0;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, b);
      b = mod_mul(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic point_t infinity_pt();
    point_t r;
    r.x_inf = 1'b1;
    r.x = 64'd0;
    r.y = 64'd0;
    return r;
  endfunction

  function automatic point_t point_sum(point_t s, point_t t, logic [63:0] a);
    logic [63:0] num, den, lam;
    point_t r;
    if (s.x_inf) return t;
    if (t.x_inf) return s;
    if (s.x == t.x) begin
      if (s.y != t.y || s.y == 0) return infinity_pt();
      num = (mod_mul(64'd3 % prime_p, mod_mul(s.x, s.x)) + a) % prime_p;
      den = mod_mul(64'd2 % prime_p, s.y);
    end else begin
      num = mod_sub(t.y, s.y);
      den = mod_sub(t.x, s.x);
    end
    lam = mod_mul(num, mod_inv(den));
    r.x_inf = 1'b0;
    r.x = mod_sub(mod_sub(mod_mul(lam, lam), s.x), t.x);
    r.y = mod_sub(mod_mul(lam, mod_sub(s.x, r.x)), s.y);
    return r;
  endfunction

  function automatic point_t reduce_pt(logic [63:0] x, logic [63:0] y);
    point_t r;
    r.x = x % prime_p;
    r.y = y % prime_p;
    r.x_inf = (r.x == 0 && r.y == 0);
    return r;
  endfunction

  function automatic ecpa_out_t point_result(ecpa_in_t w);
    point_t p, q, res;
    logic [63:0] a;
    ecpa_out_t o;
    res = infinity_pt();
    if (prime_p >= 2) begin
      a = coef_a % prime_p;
      p = reduce_pt(64'(w.px), 64'(w.py));
      q = reduce_pt(64'(w.qx), 64'(w.qy));
      case (w.operation)
        OPC_ADD: res = point_sum(p, q, a);
        OPC_SUB: begin
          if (!q.x_inf) q.y = (prime_p - q.y) % prime_p;
          res = point_sum(p, q, a);
        end
        OPC_MUL: begin
          for (int i = SCALAR_BITS - 1; i >= 0; i--) begin
            res = point_sum(res, res, a);
            if (w.scalar[i]) res = point_sum(res, p, a);
          end
        end
        default: res = infinity_pt();
      endcase
    end
    o.rx = res.x_inf ? '0 : res.x[FIELD_BITS-1:0];
    o.ry = res.x_inf ? '0 : res.y[FIELD_BITS-1:0];
    o.at_infinity = res.x_inf;
    return o;
  endfunction

  function automatic ecpa_in_t make_word(logic [1:0] op, int px, int py, int qx, int qy,
                                         int k);
    ecpa_in_t w;
    w.operation = op;
    w.px = FIELD_BITS'(px);
    w.py = FIELD_BITS'(py);
    w.qx = FIELD_BITS'(qx);
    w.qy = FIELD_BITS'(qy);
    w.scalar = SCALAR_BITS'(k);
    return w;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  // acceptance monitor and result check
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_results = {pending_results, point_result(in_data_i)};
      words_sent++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        err_count++;
      end else begin
        ecpa_out_t e;
        e = pending_results.pop_front();
        if (out_data_o.rx !== e.rx) begin
          $error("rx: expected %0d got %0d", e.rx, out_data_o.rx); err_count++;
        end
        if (out_data_o.ry !== e.ry) begin
          $error("ry: expected %0d got %0d", e.ry, out_data_o.ry); err_count++;
        end
        if (out_data_o.at_infinity !== e.at_infinity) begin
          $error("at_infinity: expected %0b got %0b", e.at_infinity,
                 out_data_o.at_infinity);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("ec_point_add_scalar_multiply_test: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        for (int i = 0; i < 3000; i++) @(negedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        n = short_gap();
        out_stall_i <= (n != 0);
        for (int i = 1; i < n; i++) @(negedge clk_i);
      end
    end
  end

  // valid stays up after the accepting edge until the next falling edge
  task automatic send_word(ecpa_in_t w);
    int g;
    g = short_gap();
    @(negedge clk_i);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      for (int i = 0; i < g; i++) @(negedge clk_i);
    end
    in_data_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_idx_i <= idx;
    cfg_data_i <= FIELD_BITS'(val);
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_CURVE_A) coef_a = 64'(val & 16'hffff);
    else prime_p = 64'(val & 16'hffff);
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(0, 65535);
    if (r == 1) return 0;
    return int'($urandom_range(0, 32'(prime_p - 64'd1)));
  endfunction

  function automatic int rand_scalar();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return $urandom_range(0, 65535);
    if (r == 1) return 0;
    return $urandom_range(1, 40);
  endfunction

  // pick random coordinates below p, a point on the curve for the b they imply
  function automatic void curve_point(output int x, output int y);
    x = int'($urandom_range(0, 32'(prime_p - 64'd1)));
    y = int'($urandom_range(0, 32'(prime_p - 64'd1)));
  endfunction

  stim_row_t directed[$];

  initial begin
    int primes[6] = '{11, 65521, 3, 97, 2, 13};
    int acoefs[6] = '{1, 65535, 0, 2, 7, 65535};
    int x, y, ox, oy;
    logic [1:0] op;
    stim_row_t row;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table under reset curve, p = 11, a = 1
    directed = '{
      '{make_word(OPC_ADD, 0, 0, 0, 0, 0), 1'b1, '{16'd0, 16'd0, 1'b1}},
      '{make_word(OPC_ADD, 0, 0, 3, 5, 0), 1'b1, '{16'd3, 16'd5, 1'b0}},
      '{make_word(OPC_ADD, 3, 5, 0, 0, 0), 1'b1, '{16'd3, 16'd5, 1'b0}},
      '{make_word(OPC_SUB, 3, 5, 0, 0, 0), 1'b1, '{16'd3, 16'd5, 1'b0}},
      '{make_word(OPC_ADD, 3, 5, 3, 6, 0), 1'b1, '{16'd0, 16'd0, 1'b1}},
      '{make_word(OPC_SUB, 3, 5, 3, 5, 0), 1'b1, '{16'd0, 16'd0, 1'b1}},
      '{make_word(OPC_ADD, 4, 0, 4, 0, 0), 1'b1, '{16'd0, 16'd0, 1'b1}},
      '{make_word(OPC_MUL, 3, 5, 0, 0, 0), 1'b1, '{16'd0, 16'd0, 1'b1}},
      '{make_word(OPC_NONE, 3, 5, 2, 7, 9), 1'b1, '{16'd0, 16'd0, 1'b1}},
      '{make_word(OPC_MUL, 3, 5, 0, 0, 1), 1'b1, '{16'd3, 16'd5, 1'b0}},
      '{make_word(OPC_ADD, 11, 22, 14, 16, 0), 1'b1, '{16'd3, 16'd5, 1'b0}},
      '{make_word(OPC_ADD, 3, 5, 3, 5, 0), 1'b0, '0},
      '{make_word(OPC_ADD, 3, 5, 2, 7, 0), 1'b0, '0},
      '{make_word(OPC_SUB, 3, 5, 2, 7, 0), 1'b0, '0},
      '{make_word(OPC_MUL, 3, 5, 0, 0, 16'hffff), 1'b0, '0},
      '{make_word(OPC_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000), 1'b0, '0},
      '{make_word(OPC_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b0, '0},
      '{make_word(OPC_SUB, 1, 0, 5, 0, 0), 1'b0, '0},
      '{make_word(OPC_MUL, 0, 0, 0, 0, 7), 1'b1, '{16'd0, 16'd0, 1'b1}}
    };
    foreach (directed[i]) begin
      if (directed[i].has_known && point_result(directed[i].word) != directed[i].known) begin
        $error("table row %0d disagrees with predictor", i);
        err_count++;
      end
      send_word(directed[i].word);
    end
    drain();

    // phases across curve settings, one with the long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MODULUS, primes[ph]);
      write_reg(CFG_CURVE_A, acoefs[ph]);
      if (ph == 1) long_hold = 1'b1;
      for (int n = 0; n < 20; n++) begin
        curve_point(x, y);
        curve_point(ox, oy);
        op = $urandom_range(0, 9) < 4 ? OPC_MUL :
             ($urandom_range(0, 9) == 0 ? OPC_NONE : 2'($urandom_range(0, 1)));
        case ($urandom_range(0, 5))
          0: begin ox = x; oy = y; end
          1: begin ox = x; oy = int'((prime_p - 64'(y)) % prime_p); end
          2: begin x = rand_coord(); y = rand_coord(); end
          default: ;
        endcase
        send_word(make_word(op, x, y, ox, oy, rand_scalar()));
      end
      drain();
    end
    // tiny modulus: everything lands at infinity
    write_reg(CFG_MODULUS, 1);
    for (int n = 0; n < 4; n++)
      send_word(make_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                          $urandom, $urandom));
    drain();

    $display("covered %0d words, %0d results over 7 curve settings incl. p of 2 and 65521",
             words_sent, results_seen);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ec_point_add_scalar_multiply_test: done, clean");
    end else begin
      $display("ec_point_add_scalar_multiply_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/ecpa_pkg.sv
src/ecpa_dp.sv
src/ecpa_ctrl.sv
src/ec_point_add_scalar_multiply.sv
sim/ec_point_add_scalar_multiply_test.sv
